### rtl/cccl_pkg.sv
// Package for the calibrated color classifier.
// Shared types, register indexes, color codes and classification thresholds.
// No dependencies.
package cccl_pkg;

   localparam int DUR_W   = 17;
   localparam int QUO_W   = 8;
   localparam int NUM_W   = DUR_W + QUO_W;
   localparam int LANES   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CODE_W  = 4;
   localparam int SUM_W   = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WHITE_RED   = 3'd0,
      CSR_WHITE_GREEN = 3'd1,
      CSR_WHITE_BLUE  = 3'd2,
      CSR_BLACK_RED   = 3'd3,
      CSR_BLACK_GREEN = 3'd4,
      CSR_BLACK_BLUE  = 3'd5,
      CSR_CAL_MASK    = 3'd6
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      CC_NOT_INIT = 4'd0,
      CC_BLACK    = 4'd1,
      CC_BLUE     = 4'd2,
      CC_DEFAULT  = 4'd3,
      CC_GRAY     = 4'd4,
      CC_GREEN    = 4'd5,
      CC_RED      = 4'd6,
      CC_WHITE    = 4'd7,
      CC_YELLOW   = 4'd8
   } color_code_type;

   localparam logic [QUO_W-1:0] YEL_R_MIN    = 8'd150;
   localparam logic [QUO_W-1:0] YEL_G_MAX    = 8'd220;
   localparam logic [QUO_W-1:0] YEL_B_MAX    = 8'd200;
   localparam logic [SUM_W-1:0] BLACK_SUM    = 10'd100;
   localparam logic [SUM_W-1:0] WHITE_SUM    = 10'd600;
   localparam logic [QUO_W-1:0] WHITE_SPREAD = 8'd40;
   localparam logic [QUO_W-1:0] GRAY_SPREAD  = 8'd30;
   localparam logic [QUO_W-1:0] RED_MIN      = 8'd240;
   localparam logic [QUO_W-1:0] GRN_G_MIN    = 8'd235;
   localparam logic [QUO_W-1:0] GRN_RB_MAX   = 8'd230;
   localparam logic [QUO_W:0]   BLUE_MARGIN  = 9'd40;

   // One reading after conditioning: per-lane distance to the black point
   // and calibration span. Disabled lanes carry a zero distance over a span of one.
   typedef struct packed {
      logic [LANES-1:0][DUR_W-1:0] delta;
      logic [LANES-1:0][DUR_W-1:0] span;
      logic                        cal;
   } cccl_item_type;

endpackage

### rtl/cccl_front.sv
// Front end: calibration registers, duration conditioning and clamping.
// Uses cccl_pkg; feeds cccl_queue.
module cccl_front import cccl_pkg::*; #(
   parameter int TIMEOUT_DURATION = 100000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_wdata,
   input  logic [DUR_W-1:0]     dur_red,
   input  logic [DUR_W-1:0]     dur_green,
   input  logic [DUR_W-1:0]     dur_blue,
   output cccl_item_type        item
);

   localparam int TO_W = $clog2(TIMEOUT_DURATION + 1);
   localparam int XW   = (TO_W > DUR_W) ? TO_W : DUR_W;
   localparam logic [XW-1:0] TIMEOUT_X = XW'(TIMEOUT_DURATION);

   logic [LANES-1:0][DUR_W-1:0] white_ff, white_in;
   logic [LANES-1:0][DUR_W-1:0] black_ff, black_in;
   logic [1:0]                  mask_ff, mask_in;
   logic [LANES-1:0][DUR_W-1:0] dur;

   assign dur[0] = dur_red;
   assign dur[1] = dur_green;
   assign dur[2] = dur_blue;

   always_comb begin
      white_in = white_ff;
      black_in = black_ff;
      mask_in  = mask_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WHITE_RED:   white_in[0] = csr_wdata;
            CSR_WHITE_GREEN: white_in[1] = csr_wdata;
            CSR_WHITE_BLUE:  white_in[2] = csr_wdata;
            CSR_BLACK_RED:   black_in[0] = csr_wdata;
            CSR_BLACK_GREEN: black_in[1] = csr_wdata;
            CSR_BLACK_BLUE:  black_in[2] = csr_wdata;
            CSR_CAL_MASK:    mask_in     = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= '0;
         black_ff <= '0;
         mask_ff  <= '0;
      end else begin
         white_ff <= white_in;
         black_ff <= black_in;
         mask_ff  <= mask_in;
      end
   end

   assign item.cal = (mask_ff == 2'b11);

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [XW-1:0]    xe, xlo, wx, bx;
      logic             lane_en;
      logic [DUR_W-1:0] xc, delta_l, span_l;

      assign wx = XW'(white_ff[l]);
      assign bx = XW'(black_ff[l]);

      always_comb begin
         // timeout and over-range both read as the full timeout
         xe = XW'(dur[l]);
         if (dur[l] == '0 || xe > TIMEOUT_X) begin
            xe = TIMEOUT_X;
         end
         xlo = (xe < wx) ? wx : xe;
         xc  = (xlo > bx) ? black_ff[l] : xlo[DUR_W-1:0];
         lane_en = item.cal && (white_ff[l] < black_ff[l]);
         if (lane_en) begin
            delta_l = black_ff[l] - xc;
            span_l  = black_ff[l] - white_ff[l];
         end else begin
            delta_l = '0;
            span_l  = DUR_W'(1);
         end
      end

      assign item.delta[l] = delta_l;
      assign item.span[l]  = span_l;
   end

endmodule

### rtl/cccl_queue.sv
// Two-entry queue between front end and divider back end.
// Uses cccl_pkg.
module cccl_queue import cccl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cccl_item_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output cccl_item_type head
);

   cccl_item_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/cccl_back.sv
// Back end: three restoring dividers (one quotient bit per cycle),
// classification and the result register. Uses cccl_pkg.
module cccl_back import cccl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  cccl_item_type       q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CODE_W-1:0]   rsp_color_code,
   output logic [QUO_W-1:0]    rsp_norm_red,
   output logic [QUO_W-1:0]    rsp_norm_green,
   output logic [QUO_W-1:0]    rsp_norm_blue
);

   localparam int CNT_W = $clog2(QUO_W);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DIV   = 3'b010,
      ST_CLASS = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        cal_ff, cal_in;
   logic [LANES-1:0][DUR_W-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DUR_W-1:0] den_ff, den_in;
   logic [LANES-1:0][QUO_W-1:0] nlo_ff, nlo_in;
   logic [LANES-1:0][QUO_W-1:0] quo_ff, quo_in;
   logic [LANES-1:0][DUR_W-1:0] rem_step, rem_load;
   logic [LANES-1:0][QUO_W-1:0] nlo_load, quo_step;

   logic                        out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]           code_ff, code_in;
   logic [LANES-1:0][QUO_W-1:0] norm_ff, norm_in;
   logic                        out_free;
   color_code_type              class_code;

   function automatic color_code_type classify(input logic [QUO_W-1:0] r,
                                               input logic [QUO_W-1:0] g,
                                               input logic [QUO_W-1:0] b);
      logic [QUO_W-1:0] mx, mn, spread;
      logic [SUM_W-1:0] sum;
      color_code_type   c;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      spread = mx - mn;
      sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
      if (r > YEL_R_MIN && g < YEL_G_MAX && b < YEL_B_MAX) c = CC_YELLOW;
      else if (sum < BLACK_SUM) c = CC_BLACK;
      else if (sum > WHITE_SUM && spread < WHITE_SPREAD) c = CC_WHITE;
      else if (spread < GRAY_SPREAD) c = CC_GRAY;
      else if (r > RED_MIN) c = CC_RED;
      else if (g > GRN_G_MIN && r < GRN_RB_MAX && b < GRN_RB_MAX) c = CC_GREEN;
      else if ({1'b0, b} > {1'b0, r} + BLUE_MARGIN && {1'b0, b} > {1'b0, g} + BLUE_MARGIN)
         c = CC_BLUE;
      else c = CC_DEFAULT;
      return c;
   endfunction

   // dividend is delta*255 < span*256, so its top DUR_W bits start below span
   for (genvar l = 0; l < LANES; l++) begin : g_div
      logic [NUM_W-1:0] num;
      logic [DUR_W:0]   trial;
      logic             ge;

      assign num = {q_head.delta[l], QUO_W'(0)} - NUM_W'(q_head.delta[l]);
      assign rem_load[l] = num[NUM_W-1:QUO_W];
      assign nlo_load[l] = num[QUO_W-1:0];

      assign trial       = {rem_ff[l], nlo_ff[l][QUO_W-1]};
      assign ge          = (trial >= {1'b0, den_ff[l]});
      assign rem_step[l] = ge ? DUR_W'(trial - {1'b0, den_ff[l]}) : trial[DUR_W-1:0];
      assign quo_step[l] = {quo_ff[l][QUO_W-2:0], ge};
   end

   assign class_code = cal_ff ? classify(quo_ff[0], quo_ff[1], quo_ff[2]) : CC_NOT_INIT;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign q_pop      = (state_ff == ST_IDLE) && q_not_empty;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cal_in       = cal_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      nlo_in       = nlo_ff;
      quo_in       = quo_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      code_in      = code_ff;
      norm_in      = norm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               rem_in   = rem_load;
               nlo_in   = nlo_load;
               den_in   = q_head.span;
               cal_in   = q_head.cal;
               quo_in   = '0;
               cnt_in   = CNT_W'(QUO_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            for (int l = 0; l < LANES; l++) begin
               nlo_in[l] = nlo_ff[l] << 1;
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               code_in      = class_code;
               norm_in      = quo_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cal_ff  <= cal_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      nlo_ff  <= nlo_in;
      quo_ff  <= quo_in;
      code_ff <= code_in;
      norm_ff <= norm_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_color_code = code_ff;
   assign rsp_norm_red   = norm_ff[0];
   assign rsp_norm_green = norm_ff[1];
   assign rsp_norm_blue  = norm_ff[2];

endmodule

### rtl/calibrated_color_classifier_top.sv
// Top level of the calibrated color classifier.
// Uses cccl_pkg, cccl_front, cccl_queue, cccl_back.
//
// channel  dir  handshake              payload
// req_     in   req_valid / req_stall  red/green/blue_duration (17 b each)
// rsp_     out  rsp_valid / rsp_stall  color_code (4 b), norm_red/green/blue (8 b)
// csr_     in   csr_valid / csr_ready  csr_index (3 b), csr_wdata (17 b)
//
// Each reading passes through the back end as one load, eight quotient bits of
// the three lane dividers, one classify into the result register. The next
// reading is loaded only after classify has written the result register, and
// classify waits while rsp_stall holds. A two-entry queue lets req_ beats be taken
// while the dividers work or a result waits under rsp_stall. Reset is synchronous
// and clears calibration registers to zero; csr_ready is always high.
module calibrated_color_classifier_top import cccl_pkg::*; #(
   parameter int TIMEOUT_DURATION = 100000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DUR_W-1:0]     req_red_duration,
   input  logic [DUR_W-1:0]     req_green_duration,
   input  logic [DUR_W-1:0]     req_blue_duration,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CODE_W-1:0]    rsp_color_code,
   output logic [QUO_W-1:0]     rsp_norm_red,
   output logic [QUO_W-1:0]     rsp_norm_green,
   output logic [QUO_W-1:0]     rsp_norm_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_wdata
);

   cccl_item_type front_item, q_head;
   logic          q_full, q_not_empty, q_pop, q_push;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   cccl_front #(
      .TIMEOUT_DURATION(TIMEOUT_DURATION)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dur_red   (req_red_duration),
      .dur_green (req_green_duration),
      .dur_blue  (req_blue_duration),
      .item      (front_item)
   );

   cccl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   cccl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_color_code (rsp_color_code),
      .rsp_norm_red   (rsp_norm_red),
      .rsp_norm_green (rsp_norm_green),
      .rsp_norm_blue  (rsp_norm_blue)
   );

endmodule

### rtl/cccl_checker.sv
// Port-level checks for the calibrated color classifier, bound to the top level.
// Uses cccl_pkg.
module cccl_checker import cccl_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CODE_W-1:0] rsp_color_code,
   input logic [QUO_W-1:0]  rsp_norm_red,
   input logic [QUO_W-1:0]  rsp_norm_green,
   input logic [QUO_W-1:0]  rsp_norm_blue
);

   logic [SUM_W-1:0] norm_sum;
   assign norm_sum = SUM_W'(rsp_norm_red) + SUM_W'(rsp_norm_green)
                   + SUM_W'(rsp_norm_blue);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_color_code)
         && $stable(rsp_norm_red) && $stable(rsp_norm_green) && $stable(rsp_norm_blue))
      else $error("result beat changed while stalled");

   a_not_init_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_code == CC_NOT_INIT |->
         rsp_norm_red == '0 && rsp_norm_green == '0 && rsp_norm_blue == '0)
      else $error("uncalibrated beat carries nonzero intensity");

   a_black_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_code == CC_BLACK |-> norm_sum < BLACK_SUM)
      else $error("black beat with bright intensities");

   a_yellow_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color_code == CC_YELLOW |-> rsp_norm_red > YEL_R_MIN)
      else $error("yellow beat with weak red");

endmodule

bind calibrated_color_classifier_top cccl_checker u_cccl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_color_code (rsp_color_code),
   .rsp_norm_red   (rsp_norm_red),
   .rsp_norm_green (rsp_norm_green),
   .rsp_norm_blue  (rsp_norm_blue)
);

### test/calibrated_color_classifier_top_test.sv
// Self-checking testbench for calibrated_color_classifier_top.
// Depends on cccl_pkg and the block's RTL; a scoreboard class predicts every reading.
// The stimulus is directed color and calibration cases, then random phases, most under stalls.
module calibrated_color_classifier_top_test;
   import cccl_pkg::*;

   localparam int TIMEOUT_US  = 100000;
   localparam int BASE_BLACK  = 1255;     // white 1000, black 1255: norm = 1255 - x
   localparam int SETTLE      = 16;       // extra wait after the scoreboard drains
   localparam int RUN_LIMIT   = 2_000_000;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [QUO_W-1:0]  red;
      logic [QUO_W-1:0]  green;
      logic [QUO_W-1:0]  blue;
   } color_result_type;

   class color_scoreboard;
      logic [DUR_W-1:0] white_pt[LANES];
      logic [DUR_W-1:0] black_pt[LANES];
      logic [1:0]       cal_mask;
      color_result_type pending_q[$];
      int               fail_count;

      function new();
         foreach (white_pt[i]) begin
            white_pt[i] = '0;
            black_pt[i] = '0;
         end
         cal_mask   = '0;
         fail_count = 0;
      endfunction

      function void set_calibration(csr_index_type idx, logic [DUR_W-1:0] data);
         case (idx)
            CSR_WHITE_RED:   white_pt[0] = data;
            CSR_WHITE_GREEN: white_pt[1] = data;
            CSR_WHITE_BLUE:  white_pt[2] = data;
            CSR_BLACK_RED:   black_pt[0] = data;
            CSR_BLACK_GREEN: black_pt[1] = data;
            CSR_BLACK_BLUE:  black_pt[2] = data;
            CSR_CAL_MASK:    cal_mask = data[1:0];
            default: ;
         endcase
      endfunction

      // timeout (0) and overlong pulses both read as the full timeout
      function logic [DUR_W-1:0] condition_pulse(logic [DUR_W-1:0] d);
         if (d == 0 || d > TIMEOUT_US) return DUR_W'(TIMEOUT_US);
         return d;
      endfunction

      function logic [QUO_W-1:0] normalize_lane(logic [DUR_W-1:0] x, int lane);
         logic [DUR_W-1:0] wht;
         logic [DUR_W-1:0] blk;
         logic [DUR_W-1:0] c;
         logic [33:0]      q;
         wht = white_pt[lane];
         blk = black_pt[lane];
         if (wht >= blk) return '0;
         c = (x < wht) ? wht : ((x > blk) ? blk : x);
         q = ((blk - c) * 34'd255) / (blk - wht);
         if (q > 255) q = 255;
         return q[QUO_W-1:0];
      endfunction

      function color_code_type pick_color(int r, int g, int b);
         int hi;
         int lo;
         int sum;
         int spread;
         hi = r;
         lo = r;
         if (g > hi) hi = g;
         if (b > hi) hi = b;
         if (g < lo) lo = g;
         if (b < lo) lo = b;
         sum    = r + g + b;
         spread = hi - lo;
         if (r > 150 && g < 220 && b < 200) return CC_YELLOW;
         if (sum < 100) return CC_BLACK;
         if (sum > 600 && spread < 40) return CC_WHITE;
         if (spread < 30) return CC_GRAY;
         if (r > 240) return CC_RED;
         if (g > 235 && r < 230 && b < 230) return CC_GREEN;
         if (b > r + 40 && b > g + 40) return CC_BLUE;
         return CC_DEFAULT;
      endfunction

      function void note_reading(logic [DUR_W-1:0] r, logic [DUR_W-1:0] g,
                                 logic [DUR_W-1:0] b);
         color_result_type res;
         if (cal_mask != 2'b11) begin
            res.code  = CC_NOT_INIT;
            res.red   = '0;
            res.green = '0;
            res.blue  = '0;
         end else begin
            res.red   = normalize_lane(condition_pulse(r), 0);
            res.green = normalize_lane(condition_pulse(g), 1);
            res.blue  = normalize_lane(condition_pulse(b), 2);
            res.code  = pick_color(res.red, res.green, res.blue);
         end
         pending_q.push_back(res);
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [CODE_W-1:0] code, logic [QUO_W-1:0] red,
                                 logic [QUO_W-1:0] green, logic [QUO_W-1:0] blue);
         color_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("%0t: result beat with nothing pending: code=%0d r=%0d g=%0d b=%0d",
                             $time, code, red, green, blue));
            return;
         end
         want = pending_q.pop_front();
         if (code !== want.code || red !== want.red || green !== want.green ||
             blue !== want.blue) begin
            report($sformatf({"%0t: mismatch exp code=%0d r=%0d g=%0d b=%0d, ",
                              "got code=%0d r=%0d g=%0d b=%0d"},
                             $time, want.code, want.red, want.green, want.blue,
                             code, red, green, blue));
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [DUR_W-1:0]     req_red_duration;
   logic [DUR_W-1:0]     req_green_duration;
   logic [DUR_W-1:0]     req_blue_duration;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CODE_W-1:0]    rsp_color_code;
   logic [QUO_W-1:0]     rsp_norm_red;
   logic [QUO_W-1:0]     rsp_norm_green;
   logic [QUO_W-1:0]     rsp_norm_blue;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [DUR_W-1:0]     csr_wdata;

   color_scoreboard sb;
   int              src_pct  = 0;
   int              sink_pct = 0;

   calibrated_color_classifier_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red_duration   (req_red_duration),
      .req_green_duration (req_green_duration),
      .req_blue_duration  (req_blue_duration),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_color_code     (rsp_color_code),
      .rsp_norm_red       (rsp_norm_red),
      .rsp_norm_green     (rsp_norm_green),
      .rsp_norm_blue      (rsp_norm_blue),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_color_code, rsp_norm_red, rsp_norm_green, rsp_norm_blue);
   end

   // result side back-pressure in bursts
   initial begin : result_sink
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && sink_pct > 0 && $urandom_range(0, 99) < sink_pct)
            hold = $urandom_range(1, 11);
         rsp_stall <= (hold > 0);
         if (hold > 0) hold--;
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_reading(logic [DUR_W-1:0] r, logic [DUR_W-1:0] g,
                               logic [DUR_W-1:0] b);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_red_duration   <= r;
      req_green_duration <= g;
      req_blue_duration  <= b;
      do @(posedge clock); while (req_stall);
      sb.note_reading(r, g, b);
   endtask

   // drive a reading that lands on the given levels under the 255-wide calibration
   task automatic send_levels(int r, int g, int b);
      send_reading(DUR_W'(BASE_BLACK - r), DUR_W'(BASE_BLACK - g), DUR_W'(BASE_BLACK - b));
   endtask

   task automatic idle_source(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [DUR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_calibration(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_lanes(logic [DUR_W-1:0] wr, logic [DUR_W-1:0] wg, logic [DUR_W-1:0] wb,
                             logic [DUR_W-1:0] br, logic [DUR_W-1:0] bg, logic [DUR_W-1:0] bb,
                             logic [DUR_W-1:0] mask);
      write_reg(CSR_WHITE_RED, wr);
      write_reg(CSR_WHITE_GREEN, wg);
      write_reg(CSR_WHITE_BLUE, wb);
      write_reg(CSR_BLACK_RED, br);
      write_reg(CSR_BLACK_GREEN, bg);
      write_reg(CSR_BLACK_BLUE, bb);
      write_reg(CSR_CAL_MASK, mask);
   endtask

   task automatic calibrate_random();
      logic [DUR_W-1:0] w[LANES];
      logic [DUR_W-1:0] b[LANES];
      logic [DUR_W-1:0] mask_word;
      for (int i = 0; i < LANES; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               w[i] = DUR_W'($urandom_range(0, 100000));
               b[i] = w[i];
            end
            1: begin
               b[i] = DUR_W'($urandom_range(0, 50000));
               w[i] = b[i] + DUR_W'($urandom_range(1, 50000));
            end
            2: begin
               w[i] = '0;
               b[i] = DUR_W'(TIMEOUT_US);
            end
            3, 4: begin
               w[i] = DUR_W'($urandom_range(0, 90000));
               b[i] = w[i] + DUR_W'($urandom_range(1, 400));
            end
            default: begin
               w[i] = DUR_W'($urandom_range(0, 50000));
               b[i] = w[i] + DUR_W'($urandom_range(1000, 50000));
            end
         endcase
      end
      // upper bits of the mask word are don't-care
      mask_word = DUR_W'($urandom);
      mask_word[1:0] = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 2)) : 2'b11;
      load_lanes(w[0], w[1], w[2], b[0], b[1], b[2], mask_word);
   endtask

   // mostly readings aimed at dark, bright or any level of the lane; some raw noise
   function automatic logic [DUR_W-1:0] pick_duration(int lane);
      int unsigned lo;
      int unsigned hi;
      int unsigned sel;
      int unsigned level;
      lo  = sb.white_pt[lane];
      hi  = sb.black_pt[lane];
      sel = $urandom_range(0, 99);
      if (sel < 8) return '0;
      if (sel < 25) return DUR_W'($urandom);
      if (hi <= lo) return DUR_W'($urandom_range(0, 100000));
      case ($urandom_range(0, 2))
         0:       level = $urandom_range(0, 40);
         1:       level = $urandom_range(200, 255);
         default: level = $urandom_range(0, 255);
      endcase
      return DUR_W'(hi - (level * (hi - lo)) / 255);
   endfunction

   initial begin : stimulus
      sb = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_red_duration   = '0;
      req_green_duration = '0;
      req_blue_duration  = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_WHITE_RED;
      csr_wdata          = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // uncalibrated after reset
      send_reading('0, '1, '0);
      send_reading('1, '0, '1);
      send_reading(17'd12345, 17'd100000, 17'd100001);

      // 255-wide span on every lane: hit each color and the threshold edges
      wait_drained();
      load_lanes(17'd1000, 17'd1000, 17'd1000, BASE_BLACK, BASE_BLACK, BASE_BLACK, 17'd3);
      send_levels(200, 100, 100);
      send_levels(10, 10, 10);
      send_levels(250, 250, 250);
      send_levels(100, 100, 100);
      send_levels(250, 240, 200);
      send_levels(100, 250, 100);
      send_levels(50, 50, 200);
      send_levels(100, 150, 60);
      send_levels(151, 219, 199);
      send_levels(150, 219, 199);
      send_reading('0, '1, 17'd500);
      send_reading(17'd100000, 17'd100001, 17'd1000);

      // equal points, white above black, black beyond the timeout
      wait_drained();
      load_lanes(17'd5000, 17'd9000, '0, 17'd5000, 17'd3000, '1, 17'd3);
      send_reading('0, 17'd50000, 17'd1);
      send_reading(17'd5000, 17'd3000, '0);
      send_reading(17'd1, '1, 17'd65536);

      // only one calibration bit set
      wait_drained();
      write_reg(CSR_CAL_MASK, 17'd1);
      send_reading(17'd4000, 17'd4000, 17'd4000);
      wait_drained();
      write_reg(CSR_CAL_MASK, 17'd2);
      send_reading(17'd4000, 17'd4000, 17'd4000);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         calibrate_random();
         src_pct  = (phase == 5) ? 0 : (phase % 3) * 20;
         sink_pct = (phase == 5) ? 0 : ((phase + 1) % 3) * 20;
         for (int k = 0; k < 66; k++) begin
            if ($urandom_range(0, 99) < src_pct) idle_source($urandom_range(1, 11));
            send_reading(pick_duration(0), pick_duration(1), pick_duration(2));
         end
      end

      wait_drained();
      if (sb.fail_count == 0 && sb.pending_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
